// File: rtl/ipv4dq_pkg.sv
// ----------------------------------------------------------------------------
// ipv4dq_pkg
// Shared types, phase codes and character helpers for the dotted quad parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4dq_pkg;

    // parse phase codes
    localparam logic [1:0] PH_LEAD  = 2'd0;
    localparam logic [1:0] PH_BODY  = 2'd1;
    localparam logic [1:0] PH_TRAIL = 2'd2;

    localparam logic [1:0]  LAST_DOT    = 2'd3;
    localparam logic [11:0] OCTET_MAX   = 12'd255;
    localparam logic [11:0] FIELD_LIMIT = 12'd2559;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    // one input transaction
    typedef struct packed {
        logic [7:0] text_byte;
        logic       byte_present;
        logic       end_of_text;
    } t_item;

    // one result transaction
    typedef struct packed {
        logic        parse_ok;
        logic [31:0] address;
    } t_result;

    // running parse state
    typedef struct packed {
        logic [1:0]  phase;
        logic        failed;
        logic        digit_seen;
        logic [1:0]  dots_seen;
        logic [11:0] field_value;
        logic [23:0] packed_octets;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:         PH_LEAD,
        failed:        1'b0,
        digit_seen:    1'b0,
        dots_seen:     2'd0,
        field_value:   12'd0,
        packed_octets: 24'd0
    };

    // space, tab, line feed, vertical tab, form feed, carriage return
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

`default_nettype wire

// File: rtl/ipv4dq_core.sv
// ----------------------------------------------------------------------------
// ipv4dq_core
// Parse state registers and the combinational update for one character.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4dq_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire ipv4dq_pkg::t_item i_item,
    output ipv4dq_pkg::t_result    o_result
);
    import ipv4dq_pkg::*;

    t_state r_state;
    t_state n_state;
    t_state upd;

    logic [11:0] times_ten;
    logic [11:0] digit_val;
    logic        field_big;

    assign times_ten = {r_state.field_value[8:0], 3'b000}
                     + {r_state.field_value[10:0], 1'b0};
    assign digit_val = {4'd0, i_item.text_byte - CH_ZERO};
    assign field_big = r_state.field_value > OCTET_MAX;

    // character update
    always_comb begin
        upd = r_state;
        if (i_item.byte_present && !r_state.failed) begin
            if (is_space(i_item.text_byte)) begin
                if (r_state.phase == PH_BODY) begin
                    upd.phase = PH_TRAIL;
                end
            end else if (r_state.phase == PH_TRAIL) begin
                upd.failed = 1'b1;
            end else begin
                upd.phase = PH_BODY;
                if (is_digit(i_item.text_byte)) begin
                    if (field_big) begin
                        upd.failed = 1'b1;
                    end else begin
                        upd.field_value = times_ten + digit_val;
                        upd.digit_seen  = 1'b1;
                    end
                end else if (i_item.text_byte == CH_DOT) begin
                    if (!r_state.digit_seen || field_big
                        || r_state.dots_seen == LAST_DOT) begin
                        upd.failed = 1'b1;
                    end else begin
                        case (r_state.dots_seen)
                            2'd0: upd.packed_octets[7:0]   = r_state.field_value[7:0];
                            2'd1: upd.packed_octets[15:8]  = r_state.field_value[7:0];
                            2'd2: upd.packed_octets[23:16] = r_state.field_value[7:0];
                            default: upd.failed = 1'b1;
                        endcase
                        upd.dots_seen   = r_state.dots_seen + 2'd1;
                        upd.field_value = 12'd0;
                        upd.digit_seen  = 1'b0;
                    end
                end else begin
                    upd.failed = 1'b1;
                end
            end
        end
    end

    // end of text verdict
    always_comb begin
        o_result.parse_ok = !upd.failed && upd.dots_seen == LAST_DOT
                         && upd.digit_seen && upd.field_value <= OCTET_MAX;
        o_result.address  = o_result.parse_ok
                          ? {upd.field_value[7:0], upd.packed_octets} : 32'd0;
    end

    // next state, back to start after the last character
    always_comb begin
        n_state = r_state;
        if (i_take) begin
            n_state = i_item.end_of_text ? STATE_RESET : upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTH
    // running value stays within one refused digit of an octet
    a_field_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.field_value <= FIELD_LIMIT)
        else $error("field value out of range");

    // end of text returns the parser to start
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_item.end_of_text |=> r_state == STATE_RESET)
        else $error("state not cleared after end of text");

    // a failed parse stays failed until the end of text
    a_fail_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.failed && !(i_take && i_item.end_of_text) |=> r_state.failed)
        else $error("failure flag dropped mid text");
`endif

endmodule

`default_nettype wire

// File: rtl/ipv4_dotted_quad_parser.sv
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_parser
// Parses IPv4 dotted quad text, one character per transaction, into a
// packed address with the first octet in bits 7:0.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------
//  in      | input     | i_in_valid, o_in_stall | i_text_byte, i_byte_present,
//          |           |                       | i_end_of_text
//  out     | output    | o_out_valid, i_out_stall | o_parse_ok, o_address
//
//  One transaction per cycle unless stalled, a rate set by the combinational
//  state update; a result is registered once its last character is consumed.
//  Characters keep flowing while a result waits; only an end of text is held
//  in the input register while the result register is still occupied.
//  Reset is synchronous and returns the parser to leading whitespace.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_dotted_quad_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_byte_present,
    input  wire logic        i_end_of_text,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_parse_ok,
    output logic [31:0]      o_address
);
    import ipv4dq_pkg::*;

    logic    r_in_valid;
    logic    n_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;
    t_result core_result;

    logic advance;
    logic accept_in;
    logic load_out;
    logic out_taken;

    // handshake control
    assign advance   = r_in_valid
                     && (!r_in.end_of_text || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign accept_in = i_in_valid && !o_in_stall;
    assign load_out  = advance && r_in.end_of_text;
    assign out_taken = r_out_valid && !i_out_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept_in) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (out_taken) begin
            n_out_valid = 1'b0;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in.text_byte    <= i_text_byte;
            r_in.byte_present <= i_byte_present;
            r_in.end_of_text  <= i_end_of_text;
        end
    end

    // parse state and update
    ipv4dq_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (advance),
        .i_item   (r_in),
        .o_result (core_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_parse_ok  = r_out.parse_ok;
    assign o_address   = r_out.address;

`ifndef SYNTH
    // a failed parse reports a zero address
    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_parse_ok |-> o_address == 32'd0)
        else $error("nonzero address on failed parse");

    // input is only held back for an end of text behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_in.end_of_text && r_out_valid && i_out_stall)
        else $error("input stalled without cause");

    // a waiting result is not overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out))
        else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

// File: tb/tb_ipv4_dotted_quad_parser.sv
// ----------------------------------------------------------------------------
// tb_ipv4_dotted_quad_parser
// Self-checking bench for the dotted quad parser. A directed set of texts
// covers the corner cases, then random texts follow: mostly well-formed
// quads with random octets, plus mutated texts and raw byte noise. A local
// parse model predicts every result, and the monitor compares each output
// transaction field by field. Both channels idle at random, and the output
// is held off for one long stretch so the parser backs up its input.
// ----------------------------------------------------------------------------

module tb_ipv4_dotted_quad_parser;

    import ipv4dq_pkg::*;

    localparam int TOTAL_ITEMS    = 575;
    localparam int HOLD_AFTER     = 250;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 10;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [7:0]  i_text_byte    = 8'd0;
    logic        i_byte_present = 1'b0;
    logic        i_end_of_text  = 1'b0;
    logic        i_out_stall    = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_parse_ok;
    logic [31:0] o_address;

    // stimulus and prediction stores
    t_item       pending_items[$];
    logic [7:0]  text_buf[$];
    t_result     quad_expected[$];
    t_state      quad_st = STATE_RESET;

    // handshake bookkeeping
    logic        in_taken     = 1'b0;
    int          chars_taken  = 0;
    int          feed_gap     = 0;
    int          stall_left   = 0;
    bit          in_calm      = 1'b0;
    bit          out_calm     = 1'b0;
    bit          hold_done    = 1'b0;
    int          idle_cycles  = 0;
    int          error_count  = 0;

    ipv4_dotted_quad_parser u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_text_byte    (i_text_byte),
        .i_byte_present (i_byte_present),
        .i_end_of_text  (i_end_of_text),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_parse_ok     (o_parse_ok),
        .o_address      (o_address)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic ws_char(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // parse model: advance on one accepted transaction, queue any result
    task automatic step_parser(input t_item it);
        t_state  s;
        t_result r;
        logic    good;
        s = quad_st;
        if (it.byte_present && !s.failed) begin
            if (ws_char(it.text_byte)) begin
                if (s.phase == PH_BODY)
                    s.phase = PH_TRAIL;
            end else if (s.phase == PH_TRAIL) begin
                s.failed = 1'b1;
            end else begin
                s.phase = PH_BODY;
                if (it.text_byte >= CH_ZERO && it.text_byte <= CH_NINE) begin
                    if (s.field_value > OCTET_MAX) begin
                        s.failed = 1'b1;
                    end else begin
                        s.field_value = s.field_value * 12'd10
                                      + {4'd0, it.text_byte - CH_ZERO};
                        s.digit_seen  = 1'b1;
                    end
                end else if (it.text_byte == CH_DOT) begin
                    if (!s.digit_seen || s.field_value > OCTET_MAX
                            || s.dots_seen == LAST_DOT) begin
                        s.failed = 1'b1;
                    end else begin
                        s.packed_octets = s.packed_octets
                            | ({16'd0, s.field_value[7:0]} << (8 * s.dots_seen));
                        s.dots_seen   = s.dots_seen + 2'd1;
                        s.field_value = 12'd0;
                        s.digit_seen  = 1'b0;
                    end
                end else begin
                    s.failed = 1'b1;
                end
            end
        end
        if (it.end_of_text) begin
            good = !s.failed && s.dots_seen == LAST_DOT && s.digit_seen
                && s.field_value <= OCTET_MAX;
            r.parse_ok = good;
            r.address  = good ? {s.field_value[7:0], s.packed_octets} : 32'd0;
            quad_expected.push_back(r);
            s = STATE_RESET;
        end
        quad_st = s;
    endtask

    // text building helpers
    task automatic add_string(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    task automatic add_ws(input int n);
        int i;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 1) == 0)
                text_buf.push_back(CH_SPACE);
            else
                text_buf.push_back(CH_TAB + 8'($urandom_range(0, 4)));
        end
    endtask

    task automatic push_item(input logic [7:0] b, input logic present, input logic last);
        t_item it;
        it.text_byte    = b;
        it.byte_present = present;
        it.end_of_text  = last;
        pending_items.push_back(it);
    endtask

    // move the text into the item queue; end on its last byte or on an
    // end-only transaction; noisy adds characterless items in between
    task automatic flush_text(input bit end_on_last, input bit noisy);
        int i;
        int n;
        n = text_buf.size();
        for (i = 0; i < n; i++) begin
            if (noisy && $urandom_range(0, 15) == 0)
                push_item(8'($urandom), 1'b0, 1'b0);
            push_item(text_buf[i], 1'b1, end_on_last && (i == n - 1));
        end
        if (!end_on_last || n == 0)
            push_item(8'($urandom), 1'b0, 1'b1);
        text_buf.delete();
    endtask

    task automatic directed_text(input string s, input bit end_on_last);
        add_string(s);
        flush_text(end_on_last, 1'b0);
    endtask

    // random well-formed quad with random spacing and octets
    task automatic build_quad();
        int k;
        int v;
        int r;
        if ($urandom_range(0, 3) == 0)
            add_ws($urandom_range(1, 3));
        for (k = 0; k < 4; k++) begin
            r = $urandom_range(0, 5);
            if (r == 0)
                v = 0;
            else if (r == 1)
                v = 255;
            else
                v = $urandom_range(0, 255);
            if ($urandom_range(0, 9) == 0)
                add_string($sformatf("%03d", v));
            else
                add_string($sformatf("%0d", v));
            if (k < 3)
                text_buf.push_back(CH_DOT);
        end
        if ($urandom_range(0, 3) == 0)
            add_ws($urandom_range(1, 3));
    endtask

    // break a quad: swap, drop or insert a byte, or blow up a field
    task automatic mutate_text();
        int idx;
        int r;
        idx = $urandom_range(0, text_buf.size() - 1);
        r   = $urandom_range(0, 4);
        case (r)
            0: begin
                text_buf[idx] = 8'($urandom);
            end
            1: begin
                text_buf.delete(idx);
            end
            2: begin
                text_buf.insert(idx, 8'($urandom));
            end
            3: begin
                text_buf.insert(idx, CH_ZERO + 8'($urandom_range(0, 9)));
                text_buf.insert(idx, CH_ZERO + 8'($urandom_range(0, 9)));
            end
            default: begin
                text_buf.insert(idx, $urandom_range(0, 1) ? CH_DOT : CH_SPACE);
            end
        endcase
    endtask

    // input driver: new transaction at the falling edge once the last one went
    always @(negedge i_clk) begin : feed
        t_item next_item;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // hold the stalled transaction
        end else if (feed_gap > 0) begin
            feed_gap   <= feed_gap - 1;
            i_in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
            next_item       = pending_items.pop_front();
            i_text_byte    <= next_item.text_byte;
            i_byte_present <= next_item.byte_present;
            i_end_of_text  <= next_item.end_of_text;
            i_in_valid     <= 1'b1;
            feed_gap       <= pick_gap(in_calm);
        end else begin
            i_in_valid <= 1'b0;
        end
        if ($urandom_range(0, 99) == 0)
            in_calm <= !in_calm;
    end

    // output stall: random bursts plus one long hold-off
    always @(negedge i_clk) begin : backpressure
        int n;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (!hold_done && chars_taken >= HOLD_AFTER) begin
            hold_done   <= 1'b1;
            stall_left  <= HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            n = pick_gap(out_calm);
            if (n > 0) begin
                stall_left  <= n - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
        if ($urandom_range(0, 99) == 0)
            out_calm <= !out_calm;
    end

    // monitor: check results first, then feed accepted input to the model
    always @(posedge i_clk) begin : watch
        t_result want;
        t_item   seen;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && !o_in_stall;
            if (o_out_valid && !i_out_stall) begin
                if (quad_expected.size() == 0) begin
                    $display("%0t: unexpected result parse_ok=%0b address=%h",
                             $time, o_parse_ok, o_address);
                    error_count++;
                end else begin
                    want = quad_expected.pop_front();
                    if (o_parse_ok !== want.parse_ok) begin
                        $display("%0t: parse_ok expected %0b actual %0b",
                                 $time, want.parse_ok, o_parse_ok);
                        error_count++;
                    end
                    if (o_address !== want.address) begin
                        $display("%0t: address expected %h actual %h",
                                 $time, want.address, o_address);
                        error_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                seen.text_byte    = i_text_byte;
                seen.byte_present = i_byte_present;
                seen.end_of_text  = i_end_of_text;
                step_parser(seen);
                chars_taken <= chars_taken + 1;
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial begin : stimulus
        int r;

        // plain extremes
        directed_text("0.0.0.0", 1'b1);
        directed_text("255.255.255.255", 1'b0);
        // every whitespace kind, split between before and after
        text_buf.push_back(CH_SPACE);
        text_buf.push_back(CH_TAB);
        text_buf.push_back(8'h0A);
        add_string("10.20.30.40");
        text_buf.push_back(8'h0B);
        text_buf.push_back(8'h0C);
        text_buf.push_back(CH_CR);
        flush_text(1'b1, 1'b0);
        // character after trailing whitespace, whitespace inside
        directed_text("1.2.3.4 x", 1'b1);
        directed_text("1.2 .3.4", 1'b1);
        // field too large at a dot and at the end, digit after a large value
        directed_text("256.1.1.1", 1'b1);
        directed_text("1.2.3.2559", 1'b0);
        directed_text("1.2.3.25599", 1'b1);
        // empty fields
        directed_text("1..2.3", 1'b1);
        directed_text(".1.2.3", 1'b1);
        directed_text("1.2.3.", 1'b0);
        // too many and too few dots
        directed_text("1.2.3.4.5", 1'b1);
        directed_text("1.2.3", 1'b1);
        // empty and whitespace-only text
        directed_text("", 1'b0);
        directed_text("   ", 1'b1);
        // other characters: letter, high byte, NUL, failure then valid tail
        directed_text("1.2.3.a", 1'b1);
        add_string("1.2");
        text_buf.push_back(8'hFF);
        add_string(".3.4");
        flush_text(1'b1, 1'b0);
        add_string("9.8.7.6");
        text_buf.push_back(8'h00);
        flush_text(1'b0, 1'b0);
        directed_text("x1.2.3.4", 1'b1);
        // characterless item inside a valid text is ignored
        add_string("192.168");
        flush_text(1'b1, 1'b0);
        begin
            t_item tail;
            tail = pending_items.pop_back();
            tail.end_of_text = 1'b0;
            pending_items.push_back(tail);
        end
        push_item(8'h41, 1'b0, 1'b0);
        directed_text(".0.1", 1'b1);
        directed_text("007.08.9.010", 1'b1);

        // random texts
        while (pending_items.size() < TOTAL_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                build_quad();
            end else if (r < 88) begin
                build_quad();
                mutate_text();
            end else begin
                repeat ($urandom_range(0, 6))
                    text_buf.push_back(8'($urandom));
            end
            flush_text($urandom_range(0, 2) != 0, 1'b1);
        end

        // reset
        i_rst_n = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // drain
        while (pending_items.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (quad_expected.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
